// File: src/hsfd_pkg.sv
// Shared types, constants and CRC function for the humidity sensor frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

  // CRC-8: polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte slots within a measurement frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Conversion constants (results in hundredths)
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
  localparam logic [15:0] HALF_SCALE  = 16'h7FFF;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  // Frame tracker view of the byte being processed
  typedef struct packed {
    logic        done;       // this byte closes a frame
    status_e     status;     // CRC verdict, meaningful with done
    logic [15:0] temp_word;  // raw temperature word held so far
    logic [15:0] hum_word;   // raw humidity word held so far
  } frame_info_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/hsfd_frame.sv
// Frame position tracking, word assembly and bytewise CRC-8 check.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_frame (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         byte_i,
  input  wire logic               start_i,
  input  wire logic               advance_i,
  output hsfd_pkg::frame_info_t   info_o
);

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_base, crc_next;
  logic [15:0] temp_word_q, temp_word_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic        temp_ok_q, temp_ok_d, temp_ok_base;
  logic        done;
  hsfd_pkg::status_e status;

  always_comb begin
    // start flag restarts the frame as if fresh out of reset
    pos_eff      = (start_i || (pos_q > hsfd_pkg::POS_H_CRC)) ? hsfd_pkg::POS_T_MSB : pos_q;
    crc_base     = start_i ? hsfd_pkg::CRC_INIT : crc_q;
    temp_ok_base = start_i ? 1'b0 : temp_ok_q;
    crc_next     = hsfd_pkg::crc8_byte(crc_base, byte_i);

    pos_d       = pos_eff + 3'd1;
    crc_d       = crc_base;
    temp_word_d = temp_word_q;
    hum_word_d  = hum_word_q;
    temp_ok_d   = temp_ok_base;
    done        = 1'b0;
    status      = hsfd_pkg::STATUS_OK;

    case (pos_eff)
      hsfd_pkg::POS_T_MSB: begin
        temp_word_d = {byte_i, temp_word_q[7:0]};
        crc_d       = crc_next;
      end
      hsfd_pkg::POS_T_LSB: begin
        temp_word_d = {temp_word_q[15:8], byte_i};
        crc_d       = crc_next;
      end
      hsfd_pkg::POS_T_CRC: begin
        temp_ok_d = (crc_base == byte_i);
        crc_d     = hsfd_pkg::CRC_INIT;
      end
      hsfd_pkg::POS_H_MSB: begin
        hum_word_d = {byte_i, hum_word_q[7:0]};
        crc_d      = crc_next;
      end
      hsfd_pkg::POS_H_LSB: begin
        hum_word_d = {hum_word_q[15:8], byte_i};
        crc_d      = crc_next;
      end
      default: begin
        // humidity CRC byte: close the frame
        done = 1'b1;
        if (!temp_ok_base) begin
          status = hsfd_pkg::STATUS_TEMP_CRC;
        end else if (crc_base != byte_i) begin
          status = hsfd_pkg::STATUS_HUM_CRC;
        end
        pos_d     = hsfd_pkg::POS_T_MSB;
        crc_d     = hsfd_pkg::CRC_INIT;
        temp_ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= hsfd_pkg::POS_T_MSB;
      crc_q       <= hsfd_pkg::CRC_INIT;
      temp_word_q <= '0;
      hum_word_q  <= '0;
      temp_ok_q   <= 1'b0;
    end else if (advance_i) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
      temp_ok_q   <= temp_ok_d;
    end
  end

  assign info_o.done      = done;
  assign info_o.status    = status;
  assign info_o.temp_word = temp_word_q;
  assign info_o.hum_word  = hum_word_q;

endmodule

`default_nettype wire

// File: src/hsfd_convert.sv
// Raw word to centidegree / centipercent conversion, divide by 65535 via fold.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_convert (
  input  wire logic [15:0]        temp_word_i,
  input  wire logic [15:0]        hum_word_i,
  output logic signed [14:0]      temp_centideg_o,
  output logic [13:0]             humidity_centipct_o
);

  logic [30:0] t_prod;
  logic [14:0] t_q0, t_quo;
  logic [16:0] t_rem;
  logic [29:0] h_prod;
  logic [13:0] h_q0, h_quo;
  logic [16:0] h_rem;

  // x / 65535 = q0 + carry, with q0 = x >> 16 and remainder lo + q0,
  // which stays below 2 * 65535 for these product ranges
  always_comb begin
    t_prod = 31'(temp_word_i) * 31'(hsfd_pkg::TEMP_SCALE) + 31'(hsfd_pkg::HALF_SCALE);
    t_q0   = t_prod[30:16];
    t_rem  = 17'(t_prod[15:0]) + 17'(t_q0);
    t_quo  = t_q0 + 15'(t_rem >= 17'(hsfd_pkg::FULL_SCALE));
    temp_centideg_o = signed'(t_quo - hsfd_pkg::TEMP_OFFSET);

    h_prod = 30'(hum_word_i) * 30'(hsfd_pkg::HUM_SCALE) + 30'(hsfd_pkg::HALF_SCALE);
    h_q0   = h_prod[29:16];
    h_rem  = 17'(h_prod[15:0]) + 17'(h_q0);
    h_quo  = h_q0 + 14'(h_rem >= 17'(hsfd_pkg::FULL_SCALE));
    humidity_centipct_o = (h_quo > hsfd_pkg::HUM_MAX) ? hsfd_pkg::HUM_MAX : h_quo;
  end

endmodule

`default_nettype wire

// File: src/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder: input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid_i / in_stall_o) carries one frame byte per request:
//   temperature MSB, LSB, CRC, humidity MSB, LSB, CRC. frame_start_i marks the
//   first byte and drops any partial frame; without it frames simply follow on.
//   Output channel (out_valid_o / out_stall_i) carries one request per frame,
//   produced by the sixth byte: temperature in 0.01 degC, humidity in 0.01 %RH
//   and a status (ok, temperature CRC error, humidity CRC error). On any CRC
//   error both values read zero; a temperature error wins over a humidity one.
// Timing
//   One byte accepted per cycle while the input is not stalled. A byte waits in
//   the input register, then CRC, word assembly and the 16x15 constant multiply
//   with the fold-by-65535 run in one stage into the result register: the result
//   is valid once the closing byte has passed the input and result registers.
// Stall
//   A held result only blocks the input when the byte in the input register
//   closes another frame; all other bytes keep flowing underneath it.
// Reset
//   rst_ni is asynchronous: both registers empty, frame position 0, CRC 0xFF.

module humidity_sensor_frame_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         frame_byte_i,
  input  wire logic               frame_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [14:0]      temp_centideg_o,
  output logic [13:0]             humidity_centipct_o,
  output logic [1:0]              frame_status_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;

  // result register
  logic              out_valid_q, out_valid_d;
  logic signed [14:0] out_temp_q;
  logic [13:0]       out_hum_q;
  logic [1:0]        out_status_q;

  hsfd_pkg::frame_info_t info;
  logic               s1_adv, s1_fire, out_busy, in_accept;
  logic signed [14:0] conv_temp;
  logic [13:0]        conv_hum;

  hsfd_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (s1_byte_q),
    .start_i   (s1_start_q),
    .advance_i (s1_fire),
    .info_o    (info)
  );

  hsfd_convert u_convert (
    .temp_word_i         (info.temp_word),
    .hum_word_i          (info.hum_word),
    .temp_centideg_o     (conv_temp),
    .humidity_centipct_o (conv_hum)
  );

  // Only a frame-closing byte needs the result slot.
  assign out_busy   = out_valid_q && out_stall_i;
  assign s1_adv     = !(info.done && out_busy);
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (s1_fire && info.done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= frame_byte_i;
      s1_start_q <= frame_start_i;
    end
  end

  // Values only reported for a clean frame
  always_ff @(posedge clk_i) begin
    if (s1_fire && info.done) begin
      out_status_q <= info.status;
      if (info.status == hsfd_pkg::STATUS_OK) begin
        out_temp_q <= conv_temp;
        out_hum_q  <= conv_hum;
      end else begin
        out_temp_q <= '0;
        out_hum_q  <= '0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temp_centideg_o     = out_temp_q;
  assign humidity_centipct_o = out_hum_q;
  assign frame_status_o      = out_status_q;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != hsfd_pkg::STATUS_OK) |->
      (temp_centideg_o == '0) && (humidity_centipct_o == '0))
    else $error("CRC error result carries nonzero values");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_centipct_o <= hsfd_pkg::HUM_MAX)
    else $error("humidity above full scale");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && info.done && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked closing byte");

  a_close_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && info.done |=> out_valid_q)
    else $error("closing byte produced no result");
`endif

endmodule

`default_nettype wire

// File: bench/tb_humidity_sensor_frame_decoder.sv
// Testbench for the humidity sensor frame decoder: CRC check, conversion, resync.
`timescale 1ns / 1ps
`default_nettype none

module tb_humidity_sensor_frame_decoder;

  // A run with no accepted request for this many cycles counts as a hang.
  // The slowest legal stretch is a sender gap plus a full receiver stall plus
  // the pipe through the input and result registers.
  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_WAIT   = 17;
  // Settling time once nothing is pending: a result lands once the closing byte
  // has passed the input and result registers, so the tail catches a stray extra result.
  localparam int TAIL_CYCLES = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  frame_byte_i  = 8'h00;
  logic        frame_start_i = 1'b0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic signed [14:0] temp_centideg_o;
  logic [13:0] humidity_centipct_o;
  logic [1:0]  frame_status_o;

  humidity_sensor_frame_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .frame_byte_i       (frame_byte_i),
    .frame_start_i      (frame_start_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .temp_centideg_o    (temp_centideg_o),
    .humidity_centipct_o(humidity_centipct_o),
    .frame_status_o     (frame_status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One decoded measurement as the block should report it
  typedef struct {
    logic signed [14:0] temp;
    logic [13:0]        hum;
    hsfd_pkg::status_e  status;
  } reading_t;

  reading_t reading_q[$];

  // Shadow of the decoder's frame state
  logic [2:0]  slot;
  logic [7:0]  crc_acc;
  logic [15:0] t_raw;
  logic [15:0] h_raw;
  logic        t_crc_good;

  int  errors = 0;
  int  idle_cycles = 0;
  int  out_hold = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;

  // CRC-8, poly 0x31, fed one data bit at a time, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ d[i];
      r  = {r[6:0], 1'b0} ^ (fb ? hsfd_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_next(crc8_next(hsfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Track one accepted byte; queue a reading when it closes a frame
  function automatic void decode_byte(input logic [7:0] b, input logic s);
    reading_t    r;
    logic [2:0]  p;
    logic        h_good;
    longint      t_scaled;
    longint      h_scaled;
    if (s) begin
      slot       = hsfd_pkg::POS_T_MSB;
      crc_acc    = hsfd_pkg::CRC_INIT;
      t_crc_good = 1'b0;
    end
    p = (slot > hsfd_pkg::POS_H_CRC) ? hsfd_pkg::POS_T_MSB : slot;
    case (p)
      hsfd_pkg::POS_T_MSB: begin
        t_raw[15:8] = b;
        crc_acc     = crc8_next(crc_acc, b);
      end
      hsfd_pkg::POS_T_LSB: begin
        t_raw[7:0] = b;
        crc_acc    = crc8_next(crc_acc, b);
      end
      hsfd_pkg::POS_T_CRC: begin
        t_crc_good = (crc_acc == b);
        crc_acc    = hsfd_pkg::CRC_INIT;
      end
      hsfd_pkg::POS_H_MSB: begin
        h_raw[15:8] = b;
        crc_acc     = crc8_next(crc_acc, b);
      end
      hsfd_pkg::POS_H_LSB: begin
        h_raw[7:0] = b;
        crc_acc    = crc8_next(crc_acc, b);
      end
      default: begin
        h_good = (crc_acc == b);
        r.temp = '0;
        r.hum  = '0;
        if (!t_crc_good) begin
          r.status = hsfd_pkg::STATUS_TEMP_CRC;
        end else if (!h_good) begin
          r.status = hsfd_pkg::STATUS_HUM_CRC;
        end else begin
          r.status = hsfd_pkg::STATUS_OK;
          // round to nearest: 65535 is odd, so no ties
          t_scaled = (17500 * longint'(t_raw) + 32767) / 65535 - 4500;
          h_scaled = (10000 * longint'(h_raw) + 32767) / 65535;
          if (h_scaled > 10000) h_scaled = 10000;
          r.temp = t_scaled[14:0];
          r.hum  = h_scaled[13:0];
        end
        reading_q.push_back(r);
        slot       = hsfd_pkg::POS_T_MSB;
        crc_acc    = hsfd_pkg::CRC_INIT;
        t_crc_good = 1'b0;
        return;
      end
    endcase
    slot = p + 3'd1;
  endfunction

  // Present one byte request after a random gap, hold it until accepted.
  // Valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic send_frame_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_byte_i  <= b;
    frame_start_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b, s);
  endtask

  // Six-byte frame; bad_t / bad_h flip bits in the matching CRC byte
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input logic bad_t, input logic bad_h, input logic flag);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = word_crc(tw) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
    hc = word_crc(hw) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
    send_frame_byte(tw[15:8], flag);
    send_frame_byte(tw[7:0], 1'b0);
    send_frame_byte(tc, 1'b0);
    send_frame_byte(hw[15:8], 1'b0);
    send_frame_byte(hw[7:0], 1'b0);
    send_frame_byte(hc, 1'b0);
  endtask

  // Raw words biased toward the ends of the range and mid-scale
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
      3: return 16'($urandom_range(0, 31));
      4: return 16'hFFFF - 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold off the sender until every pending reading has come back
  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
  endtask

  // Full-scale words, all-zero and all-one bytes, every status, both flag
  // values, back-to-back frames and a restart in the middle of a frame.
  task automatic test_directed();
    send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);   // follows on, no flag
    send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);   // temp error wins
    send_frame_byte(8'hA5, 1'b1);                       // partial frame ...
    send_frame_byte(8'h5A, 1'b0);
    send_frame(16'h1234, 16'hBEEF, 1'b0, 1'b1, 1'b1);   // ... dropped; humidity error
  endtask

  // Mostly clean frames with random content, some CRC errors, idling toggled
  task automatic test_random_frames(input int frames);
    for (int i = 0; i < frames; i++) begin
      if ($urandom_range(0, 15) == 0) in_idle_on  = !in_idle_on;
      if ($urandom_range(0, 15) == 0) out_idle_on = !out_idle_on;
      if (i == frames / 2) drain_readings();
      send_frame(pick_raw(), pick_raw(),
                 $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                 $urandom_range(0, 1) == 1);
    end
  endtask

  // Raw noise: random bytes with start flags at arbitrary positions
  task automatic test_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_frame_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  // Broken frames of 1..5 bytes, then a frame opened by the flag, at times with a humidity CRC error
  task automatic test_resync(input int rounds);
    int len;
    for (int i = 0; i < rounds; i++) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        send_frame_byte(8'($urandom), (k == 0) && ($urandom_range(0, 1) == 1));
      end
      send_frame(pick_raw(), pick_raw(), 1'b0, $urandom_range(0, 7) == 0, 1'b1);
    end
  endtask

  // Result side: check each accepted request, then stall a random count
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reading_q.size() == 0) begin
        $error("unexpected reading: temp %0d hum %0d status %0d",
               temp_centideg_o, humidity_centipct_o, frame_status_o);
        errors++;
      end else begin
        automatic reading_t want = reading_q.pop_front();
        if (temp_centideg_o !== want.temp) begin
          $error("temp_centideg: expected %0d, got %0d", want.temp, temp_centideg_o);
          errors++;
        end
        if (humidity_centipct_o !== want.hum) begin
          $error("humidity_centipct: expected %0d, got %0d", want.hum, humidity_centipct_o);
          errors++;
        end
        if (frame_status_o !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, frame_status_o);
          errors++;
        end
      end
      out_hold = out_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall_i <= (out_hold != 0);
  end

  // Hang detector: cycles in which neither channel moves a request
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_humidity_sensor_frame_decoder: FAIL");
      $finish;
    end
  end

  initial begin
    slot       = hsfd_pkg::POS_T_MSB;
    crc_acc    = hsfd_pkg::CRC_INIT;
    t_raw      = '0;
    h_raw      = '0;
    t_crc_good = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_frames(150);
    test_noise(200);
    test_resync(30);

    in_valid_i <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_humidity_sensor_frame_decoder: PASS");
    end else begin
      $display("tb_humidity_sensor_frame_decoder: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/hsfd_pkg.sv
src/hsfd_frame.sv
src/hsfd_convert.sv
src/humidity_sensor_frame_decoder.sv
bench/tb_humidity_sensor_frame_decoder.sv
